[hdl/dpx_pkg.sv]
// Package for the depth pixel to XYZ block.
// Holds frame limits, register codes and reset values, the sequencer state type
// and the request and response types of the shared divider. No dependencies.
package dpx_pkg;

    // Frame size limits and counter widths.
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // Field and register widths.
    localparam int DEPTH_W  = 16;
    localparam int SIZE_W   = 13;
    localparam int FOCAL_W  = 24;
    localparam int CENTER_W = 20;
    localparam int SCALE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;

    // Arithmetic widths: operands of the shared multiplier, numerator and divider.
    localparam int MUL_W    = 24;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int NUM_W    = 36;
    localparam int FRAC_SH  = 24;
    localparam int QUOT_W   = 32;
    localparam int NUM_HI_W = NUM_W + FRAC_SH - QUOT_W;
    localparam int DEN_W    = PROD_W;

    // Saturation limits.
    localparam logic [QUOT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [QUOT_W-1:0] SAT_NEG = 32'h8000_0000;

    // Register reset values.
    localparam logic [SIZE_W-1:0]   RST_FRAME_COLUMNS = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_FRAME_ROWS    = 13'd480;
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_X       = 24'd131072;
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_Y       = 24'd131072;
    localparam logic [CENTER_W-1:0] RST_CENTER_X      = 20'd81920;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y      = 20'd61440;
    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE   = 24'd256000;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_COLUMNS = 3'd0,
        CFG_FRAME_ROWS    = 3'd1,
        CFG_FOCAL_X       = 3'd2,
        CFG_FOCAL_Y       = 3'd3,
        CFG_CENTER_X      = 3'd4,
        CFG_CENTER_Y      = 3'd5,
        CFG_DEPTH_SCALE   = 3'd6
    } t_cfg_idx;

    // Which coordinate the sequencer is working on.
    typedef enum logic [1:0] {
        OP_Z = 2'd0,
        OP_X = 2'd1,
        OP_Y = 2'd2
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_MUL_NUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } t_state;

    // Divider request and response.
    typedef struct packed {
        logic                start;
        logic [NUM_HI_W-1:0] num_hi;
        logic [QUOT_W-1:0]   num_lo;
        logic [DEN_W-1:0]    den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

[hdl/dpx_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all three coordinates.
// Flags a quotient that does not fit in 32 bits before it starts.
// Depends on dpx_pkg.
module dpx_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dpx_pkg::t_div_req i_req,
    output dpx_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(dpx_pkg::QUOT_W);

    logic [dpx_pkg::DEN_W-1:0]  r_rem;
    logic [dpx_pkg::DEN_W-1:0]  r_den;
    logic [dpx_pkg::QUOT_W-1:0] r_qn;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_sat;

    logic [dpx_pkg::DEN_W:0]    trial;
    logic [dpx_pkg::DEN_W:0]    diff;
    logic                       fits;
    logic                       start_sat;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        trial     = {r_rem, r_qn[dpx_pkg::QUOT_W-1]};
        diff      = trial - {1'b0, r_den};
        fits      = trial >= {1'b0, r_den};
        start_sat = {{(dpx_pkg::DEN_W - dpx_pkg::NUM_HI_W){1'b0}}, i_req.num_hi} >= i_req.den;
    end

    // Control: load on start, step while busy, pulse done at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= !start_sat;
            r_done <= start_sat;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(dpx_pkg::QUOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: remainder and the combined numerator and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= dpx_pkg::DEN_W'(i_req.num_hi);
            r_qn  <= i_req.num_lo;
            r_den <= i_req.den;
            r_sat <= start_sat;
        end else if (r_busy) begin
            r_rem <= fits ? diff[dpx_pkg::DEN_W-1:0] : trial[dpx_pkg::DEN_W-1:0];
            r_qn  <= {r_qn[dpx_pkg::QUOT_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.quot = r_qn;

    // The partial remainder stays below the divisor throughout the division.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder reached the divisor");

    // Done is a single-cycle beat that never overlaps a running division.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    // A start either begins stepping or reports saturation next cycle.
    a_start_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> (r_busy != r_done))
        else $error("divider start gave no response");

endmodule

[hdl/depth_pixel_to_xyz.sv]
// Top level of the depth pixel to XYZ block: register file, pixel counters,
// shared multiplier, sequencer and output register. Depends on dpx_pkg and dpx_div.
//
// Usage:
// Depth pixels arrive in raster order on the input channel (i_valid, o_ready,
// i_depth_raw). Each beat gives one point on the output channel (o_valid,
// i_ready, o_point_x/y/z, o_frame_end), in the same order. Column and row
// counters place each pixel in the frame and wrap at the configured size;
// o_frame_end marks the frame's last pixel.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data
// while no pixel is in flight; an index beyond the register list is ignored.
// Sequence: o_ready stays low from accept until the point is finished, so a
// new pixel is not taken while one is in flight. Each of z, x and y uses the
// shared 24x24 multiplier, then one load of the bit-serial divider and the
// division; a saturating quotient skips its 32 division steps.
// Stalls: the finished point sits in an output register, and o_ready rises
// again as soon as it is loaded there, so the next pixel is processed while the
// receiver holds off. A second point waits in the sequencer until the first is
// taken.
// Reset: synchronous, active low; registers return to their defaults, the
// counters go to zero and both channels go idle.
module depth_pixel_to_xyz (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [dpx_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [dpx_pkg::CFG_W-1:0]      i_cfg_data,
    // Depth pixel input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dpx_pkg::DEPTH_W-1:0]    i_depth_raw,
    // Point output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [31:0]             o_point_x,
    output logic signed [31:0]             o_point_y,
    output logic [30:0]                    o_point_z,
    output logic                           o_frame_end
);

    // Configuration registers
    logic [dpx_pkg::SIZE_W-1:0]   r_frame_columns;
    logic [dpx_pkg::SIZE_W-1:0]   r_frame_rows;
    logic [dpx_pkg::FOCAL_W-1:0]  r_focal_x;
    logic [dpx_pkg::FOCAL_W-1:0]  r_focal_y;
    logic [dpx_pkg::CENTER_W-1:0] r_center_x;
    logic [dpx_pkg::CENTER_W-1:0] r_center_y;
    logic [dpx_pkg::SCALE_W-1:0]  r_depth_scale;

    // Pixel position and sequencer
    logic [dpx_pkg::COL_W-1:0]    r_col_cnt;
    logic [dpx_pkg::ROW_W-1:0]    r_row_cnt;
    logic [dpx_pkg::COL_W-1:0]    r_col;
    logic [dpx_pkg::ROW_W-1:0]    r_row;
    logic [dpx_pkg::DEPTH_W-1:0]  r_depth;
    logic                         r_last;
    dpx_pkg::t_state              r_state;
    dpx_pkg::t_state              n_state;
    dpx_pkg::t_op                 r_op;

    // Arithmetic holding registers
    logic [dpx_pkg::CENTER_W-1:0] r_mag;
    logic                         r_neg;
    logic [dpx_pkg::DEN_W-1:0]    r_den;
    logic [dpx_pkg::NUM_W-1:0]    r_num;
    logic [31:0]                  r_res_x;
    logic [31:0]                  r_res_y;
    logic [30:0]                  r_res_z;

    // Output register
    logic                         r_out_valid;
    logic [31:0]                  r_out_x;
    logic [31:0]                  r_out_y;
    logic [30:0]                  r_out_z;
    logic                         r_out_last;

    logic                         accept;
    logic [dpx_pkg::COL_W-1:0]    cols_m1;
    logic [dpx_pkg::ROW_W-1:0]    rows_m1;
    logic                         last_col;
    logic                         last_row;
    logic [dpx_pkg::SCALE_W-1:0]  scale_nz;
    logic [dpx_pkg::FOCAL_W-1:0]  focal_nz;
    logic [dpx_pkg::CENTER_W-1:0] pos_q8;
    logic [dpx_pkg::CENTER_W-1:0] ctr_q8;
    logic [dpx_pkg::MUL_W-1:0]    mul_a;
    logic [dpx_pkg::MUL_W-1:0]    mul_b;
    logic [dpx_pkg::PROD_W-1:0]   mul_p;
    logic [30:0]                  z_val;
    logic [31:0]                  lat_val;
    logic                         out_free;
    dpx_pkg::t_div_req            div_req;
    dpx_pkg::t_div_rsp            div_rsp;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_columns <= dpx_pkg::RST_FRAME_COLUMNS;
            r_frame_rows    <= dpx_pkg::RST_FRAME_ROWS;
            r_focal_x       <= dpx_pkg::RST_FOCAL_X;
            r_focal_y       <= dpx_pkg::RST_FOCAL_Y;
            r_center_x      <= dpx_pkg::RST_CENTER_X;
            r_center_y      <= dpx_pkg::RST_CENTER_Y;
            r_depth_scale   <= dpx_pkg::RST_DEPTH_SCALE;
        end else if (i_cfg_wr_en) begin
            unique case (dpx_pkg::t_cfg_idx'(i_cfg_index))
                dpx_pkg::CFG_FRAME_COLUMNS: r_frame_columns <= i_cfg_data[dpx_pkg::SIZE_W-1:0];
                dpx_pkg::CFG_FRAME_ROWS:    r_frame_rows    <= i_cfg_data[dpx_pkg::SIZE_W-1:0];
                dpx_pkg::CFG_FOCAL_X:       r_focal_x       <= i_cfg_data[dpx_pkg::FOCAL_W-1:0];
                dpx_pkg::CFG_FOCAL_Y:       r_focal_y       <= i_cfg_data[dpx_pkg::FOCAL_W-1:0];
                dpx_pkg::CFG_CENTER_X:      r_center_x      <= i_cfg_data[dpx_pkg::CENTER_W-1:0];
                dpx_pkg::CFG_CENTER_Y:      r_center_y      <= i_cfg_data[dpx_pkg::CENTER_W-1:0];
                dpx_pkg::CFG_DEPTH_SCALE:   r_depth_scale   <= i_cfg_data[dpx_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size minus one, clamped to the counter range.
    always_comb begin
        if (r_frame_columns == '0) begin
            cols_m1 = '0;
        end else if (r_frame_columns > dpx_pkg::SIZE_W'(dpx_pkg::MAX_COLUMNS)) begin
            cols_m1 = dpx_pkg::COL_W'(dpx_pkg::MAX_COLUMNS - 1);
        end else begin
            cols_m1 = dpx_pkg::COL_W'(r_frame_columns - 1'b1);
        end
        if (r_frame_rows == '0) begin
            rows_m1 = '0;
        end else if (r_frame_rows > dpx_pkg::SIZE_W'(dpx_pkg::MAX_ROWS)) begin
            rows_m1 = dpx_pkg::ROW_W'(dpx_pkg::MAX_ROWS - 1);
        end else begin
            rows_m1 = dpx_pkg::ROW_W'(r_frame_rows - 1'b1);
        end
        last_col = r_col_cnt >= cols_m1;
        last_row = r_row_cnt >= rows_m1;
    end

    assign accept = i_valid && o_ready;

    // Pixel counters advance on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= last_row ? '0 : r_row_cnt + 1'b1;
            end else begin
                r_col_cnt <= r_col_cnt + 1'b1;
            end
        end
    end

    // Shared multiplier: divisor in one cycle, numerator in the next.
    always_comb begin
        scale_nz = (r_depth_scale == '0) ? dpx_pkg::SCALE_W'(1) : r_depth_scale;
        if (r_op == dpx_pkg::OP_Y) begin
            focal_nz = (r_focal_y == '0) ? dpx_pkg::FOCAL_W'(1) : r_focal_y;
            pos_q8   = dpx_pkg::CENTER_W'({r_row, 8'h00});
            ctr_q8   = r_center_y;
        end else begin
            focal_nz = (r_focal_x == '0) ? dpx_pkg::FOCAL_W'(1) : r_focal_x;
            pos_q8   = dpx_pkg::CENTER_W'({r_col, 8'h00});
            ctr_q8   = r_center_x;
        end
        if (r_state == dpx_pkg::ST_MUL_DEN) begin
            mul_a = dpx_pkg::MUL_W'(scale_nz);
            mul_b = (r_op == dpx_pkg::OP_Z) ? dpx_pkg::MUL_W'(1) : dpx_pkg::MUL_W'(focal_nz);
        end else begin
            mul_a = (r_op == dpx_pkg::OP_Z) ? dpx_pkg::MUL_W'(1) : dpx_pkg::MUL_W'(r_mag);
            mul_b = dpx_pkg::MUL_W'(r_depth);
        end
        mul_p = mul_a * mul_b;
    end

    // Divider request: numerator is the product shifted up by 24 bits.
    always_comb begin
        div_req.start  = (r_state == dpx_pkg::ST_DIV_START);
        div_req.num_hi = r_num[dpx_pkg::NUM_W-1:dpx_pkg::NUM_W-dpx_pkg::NUM_HI_W];
        div_req.num_lo = {r_num[dpx_pkg::NUM_W-dpx_pkg::NUM_HI_W-1:0],
                          {dpx_pkg::FRAC_SH{1'b0}}};
        div_req.den    = r_den;
    end

    dpx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Saturation of the quotient for each coordinate.
    always_comb begin
        z_val = (div_rsp.sat || div_rsp.quot[31]) ? dpx_pkg::SAT_POS[30:0] : div_rsp.quot[30:0];
        if (r_neg) begin
            lat_val = (div_rsp.sat || div_rsp.quot > dpx_pkg::SAT_NEG)
                    ? dpx_pkg::SAT_NEG : (32'd0 - div_rsp.quot);
        end else begin
            lat_val = (div_rsp.sat || div_rsp.quot[31]) ? dpx_pkg::SAT_POS : div_rsp.quot;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            dpx_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = dpx_pkg::ST_MUL_DEN;
                end
            end
            dpx_pkg::ST_MUL_DEN:   n_state = dpx_pkg::ST_MUL_NUM;
            dpx_pkg::ST_MUL_NUM:   n_state = dpx_pkg::ST_DIV_START;
            dpx_pkg::ST_DIV_START: n_state = dpx_pkg::ST_DIV_WAIT;
            dpx_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_op == dpx_pkg::OP_Y) ? dpx_pkg::ST_FINISH : dpx_pkg::ST_MUL_DEN;
                end
            end
            dpx_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = dpx_pkg::ST_IDLE;
                end
            end
            default: n_state = dpx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpx_pkg::ST_IDLE;
            r_op    <= dpx_pkg::OP_Z;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_op <= dpx_pkg::OP_Z;
            end else if (r_state == dpx_pkg::ST_DIV_WAIT && div_rsp.done) begin
                r_op <= (r_op == dpx_pkg::OP_Z) ? dpx_pkg::OP_X : dpx_pkg::OP_Y;
            end
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_depth <= i_depth_raw;
            r_col   <= r_col_cnt;
            r_row   <= r_row_cnt;
            r_last  <= last_col && last_row;
        end
        if (r_state == dpx_pkg::ST_MUL_DEN) begin
            r_den <= mul_p;
            r_neg <= ctr_q8 > pos_q8;
            r_mag <= (ctr_q8 > pos_q8) ? (ctr_q8 - pos_q8) : (pos_q8 - ctr_q8);
        end
        if (r_state == dpx_pkg::ST_MUL_NUM) begin
            r_num <= mul_p[dpx_pkg::NUM_W-1:0];
        end
        if (r_state == dpx_pkg::ST_DIV_WAIT && div_rsp.done) begin
            unique case (r_op)
                dpx_pkg::OP_Z: r_res_z <= z_val;
                dpx_pkg::OP_X: r_res_x <= lat_val;
                dpx_pkg::OP_Y: r_res_y <= lat_val;
                default: ;
            endcase
        end
    end

    // Output register: loaded when the point is finished and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == dpx_pkg::ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dpx_pkg::ST_FINISH && out_free) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_z    <= r_res_z;
            r_out_last <= r_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r_out_z;
    assign o_frame_end = r_out_last;

    // An accepted pixel at the frame's end brings both counters back to zero.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col && last_row) |=> (r_col_cnt == '0 && r_row_cnt == '0))
        else $error("counters did not wrap at frame end");

    // A divider result only arrives while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == dpx_pkg::ST_DIV_WAIT))
        else $error("divider result arrived outside the wait state");

    // A stalled output beat is never overwritten by the next point.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_x) && $stable(r_out_z)))
        else $error("stalled output point was overwritten");

endmodule
